### rtl/core/pdc_pkg.sv
// shared types and constants of the dual stream pcr delta checker
// no dependencies

package pdc_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int PCR_W   = 42;
	localparam int TIME_W  = 64;
	localparam int WIN_W   = 32;
	localparam int LIMIT_W = 4;
	localparam int CFG_W   = 42;
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_MATCH_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_SYNC_WINDOW     = 2'd1;
	localparam logic [IDX_W-1:0] REG_QUEUE_LIMIT     = 2'd2;

	localparam logic [PCR_W-1:0]   MATCH_THRESHOLD_RST = PCR_W'(27000);
	localparam logic [WIN_W-1:0]   SYNC_WINDOW_RST     = WIN_W'(135000);
	localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST     = LIMIT_W'(10);

	typedef struct packed {
		logic [PCR_W-1:0]  pcr;
		logic [TIME_W-1:0] arrival;
	} pdc_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clr;
	} pdc_qctl_t;

endpackage

### rtl/core/pdc_if.sv
// valid/ready channel interfaces for samples and results
// depends on pdc_pkg

interface pdc_in_if
	import pdc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              source;
	logic              pcr_present;
	logic [PCR_W-1:0]  pcr_value;
	logic [TIME_W-1:0] arrival_time;

	modport src (output valid, source, pcr_present, pcr_value, arrival_time, input ready);
	modport sink (input valid, source, pcr_present, pcr_value, arrival_time, output ready);
endinterface

interface pdc_out_if
	import pdc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [PCR_W-1:0] pcr_first;
	logic [PCR_W-1:0] pcr_second;
	logic [PCR_W-1:0] pcr_difference;
	logic             within_threshold;

	modport src (output valid, pcr_first, pcr_second, pcr_difference, within_threshold,
		input ready);
	modport sink (input valid, pcr_first, pcr_second, pcr_difference, within_threshold,
		output ready);
endinterface

### rtl/core/pdc_queue.sv
// per-source sample queue: register store, read pointer, fill count
// head shows the incoming sample when the queue is empty; depends on pdc_pkg

module pdc_queue
	import pdc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  pdc_qctl_t        ctl,
	input  pdc_entry_t       wdata,
	output pdc_entry_t       head,
	output logic [CNT_W-1:0] cnt_pushed,
	output logic [CNT_W-1:0] cnt
);

	pdc_entry_t        store [QUEUE_DEPTH];
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic [CNT_W:0]    slot_sum;
	logic [PTR_W-1:0]  wslot;
	logic [PTR_W-1:0]  rd_inc;

	assign do_push = ctl.push && (cnt_q != CNT_W'(QUEUE_DEPTH));

	always_comb begin
		slot_sum = (CNT_W+1)'(rd_q) + (CNT_W+1)'(cnt_q);
		if (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			slot_sum = slot_sum - (CNT_W+1)'(QUEUE_DEPTH);
		end
		wslot = slot_sum[PTR_W-1:0];
	end

	assign rd_inc     = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
	assign cnt_pushed = cnt_q + CNT_W'(do_push);
	assign head       = (cnt_q == '0) ? wdata : store[rd_q];
	assign cnt        = cnt_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store[wslot] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			cnt_q <= '0;
		end else if (ctl.clr) begin
			rd_q  <= '0;
			cnt_q <= '0;
		end else if (ctl.pop) begin
			rd_q  <= rd_inc;
			cnt_q <= cnt_pushed - CNT_W'(1);
		end else begin
			cnt_q <= cnt_pushed;
		end
	end

endmodule

### rtl/core/pdc_match.sv
// head comparison: arrival time window check, pcr difference, result register
// depends on pdc_pkg and pdc_out_if

module pdc_match
	import pdc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             emit,
	input  pdc_entry_t       head_a,
	input  pdc_entry_t       head_b,
	input  logic [PCR_W-1:0] threshold,
	input  logic [WIN_W-1:0] window,
	output logic             resync,
	output logic             room,
	pdc_out_if.src           results
);

	logic [TIME_W-1:0] tdiff;
	logic [PCR_W-1:0]  pdiff;
	logic              valid_q;
	logic [PCR_W-1:0]  first_q;
	logic [PCR_W-1:0]  second_q;
	logic [PCR_W-1:0]  diff_q;
	logic              within_q;

	assign tdiff = (head_a.arrival > head_b.arrival) ? head_a.arrival - head_b.arrival
	                                                 : head_b.arrival - head_a.arrival;
	assign resync = tdiff > TIME_W'(window);
	assign pdiff  = (head_a.pcr > head_b.pcr) ? head_a.pcr - head_b.pcr
	                                          : head_b.pcr - head_a.pcr;
	assign room   = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (room && emit) begin
			first_q  <= head_a.pcr;
			second_q <= head_b.pcr;
			diff_q   <= pdiff;
			within_q <= pdiff <= threshold;
		end
	end

	assign results.valid            = valid_q;
	assign results.pcr_first        = first_q;
	assign results.pcr_second       = second_q;
	assign results.pcr_difference   = diff_q;
	assign results.within_threshold = within_q;

endmodule

### rtl/core/dual_stream_pcr_delta_checker.sv
// top level of the dual stream pcr delta checker
// depends on pdc_pkg, pdc_if, pdc_queue and pdc_match
//
// samples: valid/ready channel of pcr samples tagged with their source stream;
//   a transfer with pcr_present low passes through and changes nothing.
// results: valid/ready channel, one transfer per matched head pair carrying
//   both pcrs, their absolute difference and the threshold flag.
// cfg: write port, cfg_we with cfg_index and cfg_data, taken while cfg_we is high;
//   write only while no sample is in flight.
// each sample lands in an input register, then is pushed to its queue while,
// in the same cycle, the queue heads are compared and popped or both cleared.
// a matched pair passes the input register, then the result register, before
// result valid rises; one sample per cycle is taken while results are drained,
// set by the combinational push/compare/pop path over the register queues.
// when results stalls the result register holds and an empty input register
// still takes one more sample; ready then drops until the result is taken.
// reset empties both queues, drops any held sample or result and loads the
// default threshold, sync window and queue limit.

module dual_stream_pcr_delta_checker
	import pdc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	pdc_in_if.sink           samples,
	pdc_out_if.src           results,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [PCR_W-1:0]   threshold_q;
	logic [WIN_W-1:0]   window_q;
	logic [LIMIT_W-1:0] limit_q;

	logic               valid_s1;
	logic               source_s1;
	logic               present_s1;
	pdc_entry_t         entry_s1;

	logic               room;
	logic               advance;
	logic               go;
	logic               both;
	logic               resync;
	logic               over_limit;
	logic               emit;
	logic               do_pop;
	logic               do_clr;
	pdc_qctl_t          ctl_a;
	pdc_qctl_t          ctl_b;
	pdc_entry_t         head_a;
	pdc_entry_t         head_b;
	logic [CNT_W-1:0]   cntp_a;
	logic [CNT_W-1:0]   cntp_b;
	logic [CNT_W-1:0]   cnt_a;
	logic [CNT_W-1:0]   cnt_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= MATCH_THRESHOLD_RST;
			window_q    <= SYNC_WINDOW_RST;
			limit_q     <= QUEUE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MATCH_THRESHOLD: begin
					threshold_q <= cfg_data[PCR_W-1:0];
				end
				REG_SYNC_WINDOW: begin
					window_q <= cfg_data[WIN_W-1:0];
				end
				REG_QUEUE_LIMIT: begin
					limit_q <= cfg_data[LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign advance       = valid_s1 && room;
	assign samples.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			source_s1        <= samples.source;
			present_s1       <= samples.pcr_present;
			entry_s1.pcr     <= samples.pcr_value;
			entry_s1.arrival <= samples.arrival_time;
		end
	end

	assign go   = advance && present_s1;
	assign both = (cntp_a != '0) && (cntp_b != '0);
	assign over_limit = ({{LIMIT_W{1'b0}}, cntp_a} > {{CNT_W{1'b0}}, limit_q})
	                 || ({{LIMIT_W{1'b0}}, cntp_b} > {{CNT_W{1'b0}}, limit_q});
	assign emit   = go && both && !resync;
	assign do_pop = emit;
	assign do_clr = go && (both ? resync : over_limit);

	assign ctl_a = '{push: go && !source_s1, pop: do_pop, clr: do_clr};
	assign ctl_b = '{push: go && source_s1, pop: do_pop, clr: do_clr};

	pdc_queue u_queue_a (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_a),
		.wdata      (entry_s1),
		.head       (head_a),
		.cnt_pushed (cntp_a),
		.cnt        (cnt_a)
	);

	pdc_queue u_queue_b (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_b),
		.wdata      (entry_s1),
		.head       (head_b),
		.cnt_pushed (cntp_b),
		.cnt        (cnt_b)
	);

	pdc_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.head_a    (head_a),
		.head_b    (head_b),
		.threshold (threshold_q),
		.window    (window_q),
		.resync    (resync),
		.room      (room),
		.results   (results)
	);

	a_one_queue_filled: assert property (@(posedge clk) disable iff (!arst_n)
		!((cnt_a != '0) && (cnt_b != '0)))
		else $error("both queues hold entries between transfers");

	a_pop_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_pop && do_clr))
		else $error("pop and clear in the same cycle");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> results.valid)
		else $error("matched head pair did not reach the result register");

	a_clr_empties: assert property (@(posedge clk) disable iff (!arst_n)
		do_clr |=> (cnt_a == '0) && (cnt_b == '0))
		else $error("queues not empty after clear");

endmodule
